@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, clocked on the rising edge and
// masked while the active-low reset is asserted
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/mrms_pkg.sv @@
// ----------------------------------------------------------------------------
// mrms_pkg
// types and codes shared by the run-mode sequencer modules
// ----------------------------------------------------------------------------
package mrms_pkg;

    // event kinds on the input channel
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_CMD    = 2'd1;
    localparam logic [1:0] FUNC_BUTTON = 2'd2;
    localparam logic [1:0] FUNC_PULSE  = 2'd3;

    // command / button selector
    localparam logic [1:0] WHICH_START  = 2'd0;
    localparam logic [1:0] WHICH_STOP   = 2'd1;
    localparam logic [1:0] WHICH_CONT   = 2'd2;
    localparam logic [1:0] WHICH_IGNORE = 2'd3;

    // run modes
    localparam logic [1:0] MODE_OFF     = 2'd0;
    localparam logic [1:0] MODE_TIMED   = 2'd1;
    localparam logic [1:0] MODE_CONT    = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR_ONE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PPR_TWO  = 2'd3;

    // register reset values
    localparam logic [19:0] PERIOD_RST   = 20'd600;
    localparam logic [15:0] DEBOUNCE_RST = 16'd50;
    localparam logic [7:0]  PPR_RST      = 8'd20;

    // tick counter cap and tenths per second
    localparam logic [15:0] TICK_CAP  = 16'hFFFF;
    localparam logic [3:0]  TENTH_TOP = 4'd9;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  which;
        logic [31:0] now_ms;
        logic        continue_pin;
        logic        motor_pick;
        logic        link_up;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  run_mode;
        logic        start_strobe;
        logic        stop_strobe;
        logic        pid_strobe;
        logic        telemetry_request;
        logic        led_level;
        logic        rev_strobe;
        logic        rev_motor;
        logic [12:0] elapsed_seconds;
    } out_item_t;

    // classified event as queued between front and back
    typedef struct packed {
        logic        is_tick;
        logic        is_cmd;
        logic        is_button;
        logic        is_pulse;
        logic        act_start;
        logic        act_stop;
        logic        act_cont;
        logic [31:0] now_ms;
        logic        pin;
        logic        motor;
        logic        link;
    } event_t;

endpackage

@@ src/mrms_front.sv @@
// ----------------------------------------------------------------------------
// mrms_front
// classifies an incoming item into a one-hot event record for the queue
// ----------------------------------------------------------------------------
module mrms_front (
    input  mrms_pkg::in_item_t item,
    output mrms_pkg::event_t   ev
);

    always_comb begin
        ev           = '0;
        ev.now_ms    = item.now_ms;
        ev.pin       = item.continue_pin;
        ev.motor     = item.motor_pick;
        ev.link      = item.link_up;
        unique case (item.func)
            mrms_pkg::FUNC_TICK:   ev.is_tick   = 1'b1;
            mrms_pkg::FUNC_CMD:    ev.is_cmd    = 1'b1;
            mrms_pkg::FUNC_BUTTON: ev.is_button = 1'b1;
            mrms_pkg::FUNC_PULSE:  ev.is_pulse  = 1'b1;
            default:               ev.is_pulse  = 1'b1;
        endcase
        unique case (item.which)
            mrms_pkg::WHICH_START:  ev.act_start = 1'b1;
            mrms_pkg::WHICH_STOP:   ev.act_stop  = 1'b1;
            mrms_pkg::WHICH_CONT:   ev.act_cont  = 1'b1;
            mrms_pkg::WHICH_IGNORE: ev.act_start = 1'b0;
            default:                ev.act_start = 1'b0;
        endcase
    end

endmodule

@@ src/mrms_queue.sv @@
// ----------------------------------------------------------------------------
// mrms_queue
// short first-in first-out buffer of classified events
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrms_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  mrms_pkg::event_t  push_data,
    output logic              not_full,
    input  logic              pop,
    output logic              not_empty,
    output mrms_pkg::event_t  pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    mrms_pkg::event_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign not_full  = (count_reg != FULL);
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `ASSERT_ALWAYS(a_count_bound, aclk, aresetn, count_reg <= FULL, "queue count past depth")
    `ASSERT_IMPLY(a_no_pop_empty, aclk, aresetn, pop, count_reg != '0, "pop from empty queue")

endmodule

@@ src/mrms_back.sv @@
// ----------------------------------------------------------------------------
// mrms_back
// executes queued events against the run state and registers one result each
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrms_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [mrms_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [mrms_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  logic                                  ev_valid,
    input  mrms_pkg::event_t                      ev,
    output logic                                  ev_pop,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output mrms_pkg::out_item_t                   res
);

    // configuration
    logic [19:0] period_reg;
    logic [15:0] window_reg;
    logic [7:0]  ppr_one_reg;
    logic [7:0]  ppr_two_reg;

    // run state
    logic [1:0]  mode_reg, mode_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [12:0] sec_reg, sec_next;
    logic [3:0]  tenth_reg, tenth_next;
    logic        held_reg, held_next;
    logic [1:0]  low_cnt_reg, low_cnt_next;
    logic [31:0] edge_time_reg [3];
    logic [31:0] edge_time_next [3];
    logic [7:0]  div_reg [2];
    logic [7:0]  div_next [2];
    logic        led_reg, led_next;

    logic                 out_valid_reg;
    mrms_pkg::out_item_t  out_reg, out_next;

    // helpers
    logic        tick_inc;
    logic [15:0] ticks_up;
    logic [12:0] sec_up;
    logic [3:0]  tenth_up;
    logic [1:0]  low_inc;
    logic [31:0] last_edge;
    logic [31:0] edge_gap;
    logic        edge_pass;
    logic [7:0]  ppr_sel;
    logic [7:0]  div_limit;
    logic [7:0]  div_old;

    assign ev_pop    = ev_valid && (!out_valid_reg || res_ready);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    assign tick_inc = (ticks_reg != mrms_pkg::TICK_CAP);
    assign ticks_up = ticks_reg + 16'(tick_inc);
    assign tenth_up = !tick_inc ? tenth_reg :
                      (tenth_reg == mrms_pkg::TENTH_TOP) ? 4'd0 : tenth_reg + 4'd1;
    assign sec_up   = (tick_inc && tenth_reg == mrms_pkg::TENTH_TOP) ? sec_reg + 13'd1
                                                                      : sec_reg;
    assign low_inc  = low_cnt_reg + 2'd1;

    always_comb begin
        unique case (1'b1)
            ev.act_stop: last_edge = edge_time_reg[1];
            ev.act_cont: last_edge = edge_time_reg[2];
            default:     last_edge = edge_time_reg[0];
        endcase
    end
    assign edge_gap  = ev.now_ms - last_edge;
    assign edge_pass = (edge_gap >= {16'd0, window_reg});

    assign ppr_sel   = ev.motor ? ppr_two_reg : ppr_one_reg;
    assign div_limit = ppr_sel - 8'd1;
    assign div_old   = ev.motor ? div_reg[1] : div_reg[0];

    always_comb begin
        logic begin_timed;
        logic begin_cont;
        logic end_now;

        begin_timed = 1'b0;
        begin_cont  = 1'b0;
        end_now     = 1'b0;

        mode_next    = mode_reg;
        ticks_next   = ticks_reg;
        sec_next     = sec_reg;
        tenth_next   = tenth_reg;
        held_next    = held_reg;
        low_cnt_next = low_cnt_reg;
        edge_time_next = edge_time_reg;
        div_next     = div_reg;
        led_next     = led_reg;
        out_next     = '0;

        priority if (ev.is_tick) begin
            if (mode_reg != mrms_pkg::MODE_OFF) begin
                ticks_next = ticks_up;
                sec_next   = sec_up;
                tenth_next = tenth_up;
                out_next.telemetry_request = ev.link;
                if (mode_reg == mrms_pkg::MODE_TIMED && {4'd0, ticks_up} >= period_reg) begin
                    end_now = 1'b1;
                end else if (mode_reg == mrms_pkg::MODE_CONT && held_reg && !ev.pin) begin
                    if (low_inc >= 2'd2) begin
                        end_now      = 1'b1;
                        held_next    = 1'b0;
                        low_cnt_next = 2'd0;
                    end else begin
                        low_cnt_next = low_inc;
                    end
                end else begin
                    low_cnt_next = 2'd0;
                end
                if (!end_now) begin
                    out_next.pid_strobe = 1'b1;
                    led_next = !led_reg;
                end
            end
        end else if (ev.is_cmd) begin
            if (ev.act_start && mode_reg == mrms_pkg::MODE_OFF) begin
                begin_timed = 1'b1;
            end else if (ev.act_stop) begin
                end_now   = 1'b1;
                held_next = 1'b0;
            end else if (ev.act_cont && mode_reg == mrms_pkg::MODE_OFF) begin
                begin_cont = 1'b1;
                held_next  = 1'b0;
            end
            out_next.telemetry_request = ev.link;
        end else if (ev.is_button) begin
            if ((ev.act_start || ev.act_stop || ev.act_cont) && edge_pass) begin
                if (ev.act_start) begin
                    edge_time_next[0] = ev.now_ms;
                    begin_timed = (mode_reg == mrms_pkg::MODE_OFF);
                end else if (ev.act_stop) begin
                    edge_time_next[1] = ev.now_ms;
                    if (mode_reg != mrms_pkg::MODE_OFF) begin
                        end_now   = 1'b1;
                        held_next = 1'b0;
                    end
                end else begin
                    edge_time_next[2] = ev.now_ms;
                    if (mode_reg == mrms_pkg::MODE_OFF && ev.pin) begin
                        begin_cont = 1'b1;
                        held_next  = 1'b1;
                    end
                end
            end
            // any action here changes the mode
            out_next.telemetry_request = ev.link && (begin_timed || begin_cont || end_now);
        end else begin
            if (div_old >= div_limit) begin
                div_next[ev.motor]  = 8'd0;
                out_next.rev_strobe = 1'b1;
                out_next.rev_motor  = ev.motor;
            end else begin
                div_next[ev.motor] = div_old + 8'd1;
            end
        end

        if (begin_timed || begin_cont) begin
            ticks_next  = 16'd0;
            sec_next    = 13'd0;
            tenth_next  = 4'd0;
            div_next[0] = 8'd1;
            div_next[1] = 8'd1;
            led_next    = 1'b1;
            mode_next   = begin_timed ? mrms_pkg::MODE_TIMED : mrms_pkg::MODE_CONT;
            out_next.start_strobe = 1'b1;
        end
        if (end_now) begin
            led_next  = 1'b0;
            mode_next = mrms_pkg::MODE_OFF;
            out_next.stop_strobe = 1'b1;
        end

        out_next.run_mode        = mode_next;
        out_next.led_level       = led_next;
        out_next.elapsed_seconds = sec_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg  <= mrms_pkg::PERIOD_RST;
            window_reg  <= mrms_pkg::DEBOUNCE_RST;
            ppr_one_reg <= mrms_pkg::PPR_RST;
            ppr_two_reg <= mrms_pkg::PPR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mrms_pkg::CFG_PERIOD:   period_reg  <= cfg_wr_data;
                mrms_pkg::CFG_DEBOUNCE: window_reg  <= cfg_wr_data[15:0];
                mrms_pkg::CFG_PPR_ONE:  ppr_one_reg <= cfg_wr_data[7:0];
                mrms_pkg::CFG_PPR_TWO:  ppr_two_reg <= cfg_wr_data[7:0];
                default:                period_reg  <= period_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= mrms_pkg::MODE_OFF;
            ticks_reg     <= '0;
            sec_reg       <= '0;
            tenth_reg     <= '0;
            held_reg      <= 1'b0;
            low_cnt_reg   <= '0;
            edge_time_reg <= '{default: '0};
            div_reg       <= '{default: '0};
            led_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (ev_pop) begin
                mode_reg      <= mode_next;
                ticks_reg     <= ticks_next;
                sec_reg       <= sec_next;
                tenth_reg     <= tenth_next;
                held_reg      <= held_next;
                low_cnt_reg   <= low_cnt_next;
                edge_time_reg <= edge_time_next;
                div_reg       <= div_next;
                led_reg       <= led_next;
                out_valid_reg <= 1'b1;
            end else if (res_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_pop) begin
            out_reg <= out_next;
        end
    end

    `ASSERT_IMPLY(a_led_off_stopped, aclk, aresetn,
        out_valid_reg && out_reg.run_mode == mrms_pkg::MODE_OFF,
        !out_reg.led_level, "led lit while stopped")
    `ASSERT_IMPLY(a_start_stop_excl, aclk, aresetn, out_valid_reg,
        !(out_reg.start_strobe && out_reg.stop_strobe), "start and stop in one result")
    `ASSERT_NEXT(a_stall_holds, aclk, aresetn, out_valid_reg && !res_ready,
        out_valid_reg && $stable(out_reg), "stalled result changed")

endmodule

@@ src/motor_run_mode_sequencer.sv @@
// a result is registered in the back stage after its beat has passed through the event queue
// throughput: one beat per cycle in both directions while m_ready stays high, bounded by the back stage
// the event queue holds QUEUE_DEPTH beats so the input side keeps taking beats while results stall, until it is full
// reset: aresetn is synchronous and active low; it clears mode, counters, dividers, edge times,
// the queue and the output valid flag, and loads the default configuration values
// ----------------------------------------------------------------------------
// motor_run_mode_sequencer
// run-mode sequencer for two motors: stopped, timed run and continuous run,
// driven by ticks, remote commands, button edges and encoder pulses
// ----------------------------------------------------------------------------
module motor_run_mode_sequencer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [mrms_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mrms_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    // event input channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mrms_pkg::in_item_t                s_data,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output mrms_pkg::out_item_t               m_data
);

    // classified event from the front, heading into the queue
    mrms_pkg::event_t front_ev;
    // head of queue, feeding the back stage
    mrms_pkg::event_t head_ev;
    logic             q_not_full;
    logic             q_not_empty;
    logic             q_pop;
    logic             q_push;

    // a beat is taken whenever the queue has room, independent of the result side
    assign s_ready = q_not_full;
    assign q_push  = s_valid && q_not_full;

    // front: decode event kind and selector into one-hot flags
    mrms_front u_front (
        .item (s_data),
        .ev   (front_ev)
    );

    // queue between front and back so each side can stall on its own
    mrms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (front_ev),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (head_ev)
    );

    // back: owns run state and configuration, registers one result per event
    mrms_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .ev_valid    (q_not_empty),
        .ev          (head_ev),
        .ev_pop      (q_pop),
        .res_valid   (m_valid),
        .res_ready   (m_ready),
        .res         (m_data)
    );

endmodule

@@ bench/run_mode_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// run_mode_checker
// watches the config port and both channels of the run-mode sequencer, keeps
// its own copy of the sequencer state, predicts one result per input beat
// and compares every result beat field by field with the oldest prediction
// ----------------------------------------------------------------------------
module run_mode_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [mrms_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrms_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  mrms_pkg::in_item_t              s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  mrms_pkg::out_item_t             m_data,
    output int                              fail_count,
    output int                              outstanding
);

    // configuration copy
    logic [19:0] period_q;
    logic [15:0] debounce_q;
    logic [7:0]  ppr_q [2];

    // sequencer state copy
    logic [1:0]  mode_q;
    logic [15:0] ticks_q;
    logic        held_q;
    logic [1:0]  low_q;
    logic [31:0] edge_ms_q [3];
    logic [7:0]  div_q [2];
    logic        led_q;

    mrms_pkg::out_item_t owed_results [$];

    initial begin
        fail_count = 0;
        outstanding = 0;
    end

    function automatic mrms_pkg::out_item_t advance_sequencer(input mrms_pkg::in_item_t ev);
        mrms_pkg::out_item_t res;
        logic [1:0] prev_mode;
        logic [1:0] start_mode;
        logic       do_start;
        logic       do_stop;
        logic [31:0] since_ms;
        logic [7:0] rev_limit;
        res = '0;
        prev_mode = mode_q;
        start_mode = mrms_pkg::MODE_TIMED;
        do_start = 1'b0;
        do_stop = 1'b0;
        case (ev.func)
            mrms_pkg::FUNC_TICK: begin
                // timer is halted while stopped
                if (mode_q != mrms_pkg::MODE_OFF) begin
                    if (ticks_q != mrms_pkg::TICK_CAP) ticks_q = ticks_q + 16'd1;
                    res.telemetry_request = ev.link_up;
                    if (mode_q == mrms_pkg::MODE_TIMED && {4'd0, ticks_q} >= period_q) begin
                        do_stop = 1'b1;
                    end else if (mode_q == mrms_pkg::MODE_CONT && held_q
                                 && !ev.continue_pin) begin
                        low_q = low_q + 2'd1;
                        if (low_q >= 2'd2) begin
                            do_stop = 1'b1;
                            held_q = 1'b0;
                            low_q = 2'd0;
                        end
                    end else begin
                        low_q = 2'd0;
                    end
                    if (!do_stop) begin
                        res.pid_strobe = 1'b1;
                        led_q = ~led_q;
                    end
                end
            end
            mrms_pkg::FUNC_CMD: begin
                if (ev.which == mrms_pkg::WHICH_START && mode_q == mrms_pkg::MODE_OFF) begin
                    do_start = 1'b1;
                end else if (ev.which == mrms_pkg::WHICH_STOP) begin
                    do_stop = 1'b1;
                    held_q = 1'b0;
                end else if (ev.which == mrms_pkg::WHICH_CONT
                             && mode_q == mrms_pkg::MODE_OFF) begin
                    do_start = 1'b1;
                    start_mode = mrms_pkg::MODE_CONT;
                    held_q = 1'b0;
                end
                res.telemetry_request = ev.link_up;
            end
            mrms_pkg::FUNC_BUTTON: begin
                if (ev.which != mrms_pkg::WHICH_IGNORE) begin
                    since_ms = ev.now_ms - edge_ms_q[ev.which];
                    if (since_ms >= {16'd0, debounce_q}) begin
                        edge_ms_q[ev.which] = ev.now_ms;
                        if (ev.which == mrms_pkg::WHICH_START) begin
                            do_start = (mode_q == mrms_pkg::MODE_OFF);
                        end else if (ev.which == mrms_pkg::WHICH_STOP) begin
                            if (mode_q != mrms_pkg::MODE_OFF) begin
                                do_stop = 1'b1;
                                held_q = 1'b0;
                            end
                        end else if (mode_q == mrms_pkg::MODE_OFF && ev.continue_pin) begin
                            do_start = 1'b1;
                            start_mode = mrms_pkg::MODE_CONT;
                            held_q = 1'b1;
                        end
                    end
                end
            end
            default: begin
                rev_limit = ppr_q[ev.motor_pick] - 8'd1;
                if (div_q[ev.motor_pick] >= rev_limit) begin
                    div_q[ev.motor_pick] = 8'd0;
                    res.rev_strobe = 1'b1;
                    res.rev_motor = ev.motor_pick;
                end else begin
                    div_q[ev.motor_pick] = div_q[ev.motor_pick] + 8'd1;
                end
            end
        endcase
        if (do_start) begin
            ticks_q = 16'd0;
            div_q[0] = 8'd1;
            div_q[1] = 8'd1;
            led_q = 1'b1;
            mode_q = start_mode;
            res.start_strobe = 1'b1;
        end
        if (do_stop) begin
            led_q = 1'b0;
            mode_q = mrms_pkg::MODE_OFF;
            res.stop_strobe = 1'b1;
        end
        // button edges only report when the mode moved
        if (ev.func == mrms_pkg::FUNC_BUTTON && mode_q != prev_mode) begin
            res.telemetry_request = ev.link_up;
        end
        res.run_mode = mode_q;
        res.led_level = led_q;
        res.elapsed_seconds = 13'(ticks_q / 16'd10);
        return res;
    endfunction

    task automatic compare_field(input string tag, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, tag, want, got);
        end
    endtask

    always @(posedge aclk) begin : watch
        mrms_pkg::out_item_t want;
        if (!aresetn) begin
            period_q = mrms_pkg::PERIOD_RST;
            debounce_q = mrms_pkg::DEBOUNCE_RST;
            ppr_q[0] = mrms_pkg::PPR_RST;
            ppr_q[1] = mrms_pkg::PPR_RST;
            mode_q = mrms_pkg::MODE_OFF;
            ticks_q = 16'd0;
            held_q = 1'b0;
            low_q = 2'd0;
            edge_ms_q[0] = 32'd0;
            edge_ms_q[1] = 32'd0;
            edge_ms_q[2] = 32'd0;
            div_q[0] = 8'd0;
            div_q[1] = 8'd0;
            led_q = 1'b0;
            owed_results.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    mrms_pkg::CFG_PERIOD:   period_q = cfg_wr_data[19:0];
                    mrms_pkg::CFG_DEBOUNCE: debounce_q = cfg_wr_data[15:0];
                    mrms_pkg::CFG_PPR_ONE:  ppr_q[0] = cfg_wr_data[7:0];
                    mrms_pkg::CFG_PPR_TWO:  ppr_q[1] = cfg_wr_data[7:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) owed_results.push_back(advance_sequencer(s_data));
            if (m_valid && m_ready) begin
                if (owed_results.size() == 0) begin
                    fail_count++;
                    $display("%0t ns: result beat with nothing pending, expected none, actual %p",
                             $time, m_data);
                end else begin
                    want = owed_results.pop_front();
                    compare_field("run_mode", want.run_mode, m_data.run_mode);
                    compare_field("start_strobe", want.start_strobe, m_data.start_strobe);
                    compare_field("stop_strobe", want.stop_strobe, m_data.stop_strobe);
                    compare_field("pid_strobe", want.pid_strobe, m_data.pid_strobe);
                    compare_field("telemetry_request", want.telemetry_request,
                                  m_data.telemetry_request);
                    compare_field("led_level", want.led_level, m_data.led_level);
                    compare_field("rev_strobe", want.rev_strobe, m_data.rev_strobe);
                    compare_field("rev_motor", want.rev_motor, m_data.rev_motor);
                    compare_field("elapsed_seconds", want.elapsed_seconds,
                                  m_data.elapsed_seconds);
                end
            end
        end
        outstanding = owed_results.size();
    end

endmodule

@@ bench/tb_motor_run_mode_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_run_mode_sequencer
// drives the run-mode sequencer with a short directed sequence, a timed run
// under a period past the tick counter cap and random run sequences under
// several register settings, with bursty input beats and a stalling result
// side; the checker beside the block predicts and compares every result beat
// ----------------------------------------------------------------------------
module tb_motor_run_mode_sequencer;

    localparam int IDLE_LIMIT       = 5000;   // cycles without any beat before giving up
    localparam int HOLD_OFF_CYCLES  = 400;    // long result-side stall, fills the event queue
    localparam int LONG_RUN_TICKS   = 30;     // running ticks under a period past the tick counter cap
    localparam int PHASE_BEATS      = 105;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            cfg_wr_en;
    logic [mrms_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mrms_pkg::CFG_DATA_W-1:0] cfg_wr_data;
    logic                            s_valid;
    logic                            s_ready;
    mrms_pkg::in_item_t              s_data;
    logic                            m_valid;
    logic                            m_ready;
    mrms_pkg::out_item_t             m_data;

    int fail_count;
    int outstanding;

    // handshake between stimulus and the result-side process for the long stall
    bit hold_off_req = 1'b0;

    int          sent_count = 0;
    int          burst_left = 0;
    logic [31:0] clock_ms;       // running button timestamp
    int          debounce_now;   // debounce window currently loaded, sizes the time steps

    always #10 aclk = ~aclk;

    motor_run_mode_sequencer u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    run_mode_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // ------------------------------------------------------------------
    // beat builders: fields an event kind does not use get random values,
    // so the block is also shown that it ignores them
    // ------------------------------------------------------------------
    function automatic mrms_pkg::in_item_t tick_beat(input logic pin, input logic link);
        mrms_pkg::in_item_t ev;
        ev.func = mrms_pkg::FUNC_TICK;
        ev.which = 2'($urandom);
        ev.now_ms = $urandom;
        ev.continue_pin = pin;
        ev.motor_pick = 1'($urandom);
        ev.link_up = link;
        return ev;
    endfunction

    function automatic mrms_pkg::in_item_t command_beat(input logic [1:0] sel,
                                                        input logic link);
        mrms_pkg::in_item_t ev;
        ev.func = mrms_pkg::FUNC_CMD;
        ev.which = sel;
        ev.now_ms = $urandom;
        ev.continue_pin = 1'($urandom);
        ev.motor_pick = 1'($urandom);
        ev.link_up = link;
        return ev;
    endfunction

    function automatic mrms_pkg::in_item_t button_beat(input logic [1:0] sel,
                                                       input logic [31:0] stamp,
                                                       input logic pin, input logic link);
        mrms_pkg::in_item_t ev;
        ev.func = mrms_pkg::FUNC_BUTTON;
        ev.which = sel;
        ev.now_ms = stamp;
        ev.continue_pin = pin;
        ev.motor_pick = 1'($urandom);
        ev.link_up = link;
        return ev;
    endfunction

    function automatic mrms_pkg::in_item_t pulse_beat(input logic motor);
        mrms_pkg::in_item_t ev;
        ev.func = mrms_pkg::FUNC_PULSE;
        ev.which = 2'($urandom);
        ev.now_ms = $urandom;
        ev.continue_pin = 1'($urandom);
        ev.motor_pick = motor;
        ev.link_up = 1'($urandom);
        return ev;
    endfunction

    // anything at all, every field random
    function automatic mrms_pkg::in_item_t noise_beat();
        mrms_pkg::in_item_t ev;
        ev.func = 2'($urandom);
        ev.which = 2'($urandom);
        ev.now_ms = $urandom;
        ev.continue_pin = 1'($urandom);
        ev.motor_pick = 1'($urandom);
        ev.link_up = 1'($urandom);
        return ev;
    endfunction

    // next button timestamp: mostly small steps around the debounce window,
    // now and then a jump anywhere or right up to the wrap point
    function automatic logic [31:0] step_clock();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll == 0) clock_ms = $urandom;
        else if (roll == 1) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
        else clock_ms = clock_ms + $urandom_range(0, 2 * debounce_now + 8);
        return clock_ms;
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // present one beat and hold it until the block takes it; called and
    // returns at a falling edge
    task automatic offer(input mrms_pkg::in_item_t ev);
        s_valid <= 1'b1;
        s_data <= ev;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        sent_count++;
    endtask

    // burst bookkeeping: at the end of a burst drop valid for a random gap,
    // except while the result side is held off so the queue fills up
    task automatic send(input mrms_pkg::in_item_t ev);
        offer(ev);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            if (!hold_off_req) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
        end
    endtask

    // stop offering and wait until every predicted result has come back,
    // then let the pipeline settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // registers only change with the block idle
    task automatic load_settings(input logic [19:0] period, input logic [15:0] window,
                                 input logic [7:0] ppr_one, input logic [7:0] ppr_two);
        logic [mrms_pkg::CFG_IDX_W-1:0]  reg_sel [4];
        logic [mrms_pkg::CFG_DATA_W-1:0] reg_val [4];
        reg_sel = '{mrms_pkg::CFG_PERIOD, mrms_pkg::CFG_DEBOUNCE,
                    mrms_pkg::CFG_PPR_ONE, mrms_pkg::CFG_PPR_TWO};
        reg_val = '{mrms_pkg::CFG_DATA_W'(period), mrms_pkg::CFG_DATA_W'(window),
                    mrms_pkg::CFG_DATA_W'(ppr_one), mrms_pkg::CFG_DATA_W'(ppr_two)};
        wait_drained();
        for (int r = 0; r < 4; r++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= reg_sel[r];
            cfg_wr_data <= reg_val[r];
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
        debounce_now = window;
    endtask

    // one run: an opening start of some kind, a body of running events,
    // and usually a stop; timed runs may also run out on their own
    task automatic play_run(input int body_len);
        int pick;
        case ($urandom_range(0, 9))
            0, 1, 2: send(command_beat(mrms_pkg::WHICH_START, 1'($urandom)));
            3, 4:    send(command_beat(mrms_pkg::WHICH_CONT, 1'($urandom)));
            5, 6:    send(button_beat(mrms_pkg::WHICH_START, step_clock(), 1'($urandom),
                                      1'($urandom)));
            default: send(button_beat(mrms_pkg::WHICH_CONT, step_clock(),
                                      $urandom_range(0, 9) != 0, 1'($urandom)));
        endcase
        for (int k = 0; k < body_len; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                // pin mostly high so that single and double low ticks both occur
                send(tick_beat($urandom_range(0, 2) != 0, 1'($urandom)));
            end else if (pick < 80) begin
                send(pulse_beat(1'($urandom)));
            end else if (pick < 90) begin
                send(button_beat(2'($urandom), step_clock(), 1'($urandom), 1'($urandom)));
            end else if (pick < 92) begin
                send(command_beat(mrms_pkg::WHICH_STOP, 1'($urandom)));
            end else begin
                case ($urandom_range(0, 2))
                    0:       send(command_beat(mrms_pkg::WHICH_START, 1'($urandom)));
                    1:       send(command_beat(mrms_pkg::WHICH_CONT, 1'($urandom)));
                    default: send(command_beat(mrms_pkg::WHICH_IGNORE, 1'($urandom)));
                endcase
            end
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            send(command_beat(mrms_pkg::WHICH_STOP, 1'($urandom)));
        end else if (pick < 8) begin
            send(button_beat(mrms_pkg::WHICH_STOP, step_clock(), 1'($urandom),
                             1'($urandom)));
        end
    endtask

    task automatic random_phase(input int count);
        int target;
        target = sent_count + count;
        while (sent_count < target) begin
            if ($urandom_range(0, 6) == 0) send(noise_beat());
            else play_run($urandom_range(2, 30));
        end
    endtask

    // ------------------------------------------------------------------
    // main stimulus and verdict
    // ------------------------------------------------------------------
    initial begin : stimulus
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = mrms_pkg::CFG_PERIOD;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_data = '0;
        clock_ms = 32'd0;
        debounce_now = mrms_pkg::DEBOUNCE_RST;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part, reset settings: period 600, debounce 50, 20 pulses per rev
        send(tick_beat(1'b0, 1'b1));                          // tick while stopped does nothing
        send(pulse_beat(1'b0));                               // dividers count while stopped
        send(pulse_beat(1'b1));
        send(command_beat(mrms_pkg::WHICH_IGNORE, 1'b1));     // ignored command still reports
        send(command_beat(mrms_pkg::WHICH_STOP, 1'b1));       // stop when already stopped
        send(button_beat(mrms_pkg::WHICH_START, 32'd10, 1'b0, 1'b1));   // inside debounce window
        send(button_beat(mrms_pkg::WHICH_START, 32'd50, 1'b0, 1'b1));   // window exactly met
        send(command_beat(mrms_pkg::WHICH_START, 1'b0));      // start while running is ignored
        send(tick_beat(1'b0, 1'b1));
        send(button_beat(mrms_pkg::WHICH_STOP, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send(button_beat(mrms_pkg::WHICH_CONT, 32'd100, 1'b0, 1'b1));   // pin low, no start
        send(button_beat(mrms_pkg::WHICH_CONT, 32'd120, 1'b1, 1'b1));   // bounced
        send(button_beat(mrms_pkg::WHICH_CONT, 32'd200, 1'b1, 1'b0));   // button-held run
        send(tick_beat(1'b0, 1'b1));                          // one low tick
        send(tick_beat(1'b1, 1'b0));                          // high pin clears the count
        send(tick_beat(1'b0, 1'b1));
        send(tick_beat(1'b0, 1'b1));                          // second low in a row stops
        send(button_beat(mrms_pkg::WHICH_CONT, 32'd300, 1'b1, 1'b1));
        send(tick_beat(1'b0, 1'b0));
        send(command_beat(mrms_pkg::WHICH_STOP, 1'b0));       // low count left stale
        send(button_beat(mrms_pkg::WHICH_CONT, 32'd400, 1'b1, 1'b1));
        send(tick_beat(1'b0, 1'b1));                          // stale count stops at once
        send(command_beat(mrms_pkg::WHICH_CONT, 1'b1));       // remote continuous, not held
        send(tick_beat(1'b0, 1'b0));
        send(button_beat(mrms_pkg::WHICH_IGNORE, 32'd0, 1'b1, 1'b1));
        send(button_beat(mrms_pkg::WHICH_STOP, 32'd0, 1'b0, 1'b1));     // wraps, still bounced
        send(command_beat(mrms_pkg::WHICH_STOP, 1'b1));

        // extremes: zero period ends a timed run on its first tick,
        // one pulse per rev on motor one and 255 on motor two
        load_settings(20'd0, 16'd0, 8'd1, 8'd255);
        random_phase(PHASE_BEATS);

        // long result-side stall while the input side keeps pushing
        load_settings(20'd1, 16'hFFFF, 8'd255, 8'd1);
        hold_off_req = 1'b1;
        random_phase(PHASE_BEATS);

        load_settings(20'd5, 16'd20, 8'd3, 8'd7);
        random_phase(PHASE_BEATS);

        load_settings(20'd12, 16'd100, 8'd2, 8'd128);
        random_phase(PHASE_BEATS);

        load_settings(20'($urandom_range(0, 40)), 16'($urandom_range(0, 300)),
                      8'($urandom_range(1, 255)), 8'($urandom_range(1, 8)));
        random_phase(PHASE_BEATS);

        load_settings(20'($urandom_range(0, 655350)), 16'($urandom),
                      8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
        random_phase(PHASE_BEATS);

        // period past the tick counter cap: a timed run that the period does not end
        load_settings(20'd655350, 16'd0, 8'd4, 8'd9);
        send(command_beat(mrms_pkg::WHICH_START, 1'b1));
        for (int n = 0; n < LONG_RUN_TICKS; n++) begin
            send(tick_beat(1'($urandom), 1'($urandom)));
        end
        send(command_beat(mrms_pkg::WHICH_STOP, 1'b1));

        load_settings(20'd8, 16'd30, 8'd5, 8'd6);
        random_phase(PHASE_BEATS);

        wait_drained();
        repeat (8) @(negedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stall patterns in stretches, plus one long
    // hold-off counted here when the stimulus asks for it
    // ------------------------------------------------------------------
    initial begin : result_sink
        int style;
        int span;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end else begin
                style = $urandom_range(0, 3);
                span = $urandom_range(8, 60);
                repeat (span) begin
                    case (style)
                        0:       m_ready <= 1'b1;                         // no stalls
                        1:       m_ready <= ($urandom_range(0, 1) == 1);
                        2:       m_ready <= ($urandom_range(0, 4) != 0);  // rare stalls
                        default: m_ready <= ($urandom_range(0, 3) == 0);  // mostly stalled
                    endcase
                    @(negedge aclk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: too long without a beat on either channel ends the run
    // ------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
            else quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
